FILE: rtl/core/fks_pkg.sv
package fks_pkg;

    // 9.8 in Q16.16
    localparam logic [19:0] DECEL_PER_COEF = 20'd642253;
    localparam logic [15:0] FRICTION_RESET = 16'd256;

    typedef enum logic [1:0] {
        MODE_REST,
        MODE_FREE,
        MODE_STOP,
        MODE_MOVE
    } mode_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] elapsed_time;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               stopped;
        logic               saturated;
    } out_word_t;

    // per-body values carried alongside the arithmetic
    typedef struct packed {
        logic signed [31:0] p_x;
        logic signed [31:0] p_y;
        logic [31:0]        vm_x;
        logic [31:0]        vm_y;
        logic               neg_x;
        logic               neg_y;
        logic [30:0]        t;
    } body_t;

    typedef struct packed {
        body_t       body;
        logic [58:0] at;
    } sqrt_side_t;

    typedef struct packed {
        body_t body;
        mode_t mode;
    } div_side_t;

endpackage

FILE: rtl/core/fks_sqrt.sv
module fks_sqrt import fks_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] in_x,
    input  sqrt_side_t  in_side,
    output logic        out_valid,
    output logic [31:0] out_root,
    output sqrt_side_t  out_side
);

    localparam int Steps = 32;

    logic [63:0] x_reg    [0:Steps];
    logic [63:0] r_reg    [0:Steps];
    logic        valid_reg[0:Steps];
    sqrt_side_t  side_reg [0:Steps];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
        if (en) begin
            x_reg[0]    <= in_x;
            r_reg[0]    <= '0;
            side_reg[0] <= in_side;
        end
    end

    // one result bit per stage, test bit walks down two places each time
    for (genvar k = 0; k < Steps; k++) begin : g_step
        localparam logic [63:0] StepBit = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        logic [63:0] x_next;
        logic [63:0] r_next;

        always_comb begin
            trial = r_reg[k] + StepBit;
            if (x_reg[k] >= trial) begin
                x_next = x_reg[k] - trial;
                r_next = (r_reg[k] >> 1) + StepBit;
            end else begin
                x_next = x_reg[k];
                r_next = r_reg[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= valid_reg[k];
            end
            if (en) begin
                x_reg[k+1]    <= x_next;
                r_reg[k+1]    <= r_next;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[Steps];
    assign out_root  = r_reg[Steps][31:0];
    assign out_side  = side_reg[Steps];

endmodule

FILE: rtl/core/fks_div.sv
module fks_div import fks_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] in_dividend_x,
    input  logic [63:0] in_dividend_y,
    input  logic [31:0] in_divisor,
    input  div_side_t   in_side,
    output logic        out_valid,
    output logic [63:0] out_quot_x,
    output logic [63:0] out_quot_y,
    output div_side_t   out_side
);

    localparam int Steps = 64;

    // dq holds the dividend bits not yet used, quotient bits shift in below
    logic [31:0] rem_x_reg [0:Steps];
    logic [31:0] rem_y_reg [0:Steps];
    logic [63:0] dq_x_reg  [0:Steps];
    logic [63:0] dq_y_reg  [0:Steps];
    logic [31:0] dvs_reg   [0:Steps];
    logic        valid_reg [0:Steps];
    div_side_t   side_reg  [0:Steps];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
        if (en) begin
            rem_x_reg[0] <= '0;
            rem_y_reg[0] <= '0;
            dq_x_reg[0]  <= in_dividend_x;
            dq_y_reg[0]  <= in_dividend_y;
            dvs_reg[0]   <= in_divisor;
            side_reg[0]  <= in_side;
        end
    end

    for (genvar k = 0; k < Steps; k++) begin : g_step
        logic [32:0] trial_x;
        logic [32:0] trial_y;
        logic [31:0] rem_x_next;
        logic [31:0] rem_y_next;
        logic        bit_x;
        logic        bit_y;

        always_comb begin
            trial_x = {rem_x_reg[k], dq_x_reg[k][63]};
            trial_y = {rem_y_reg[k], dq_y_reg[k][63]};
            bit_x   = trial_x >= {1'b0, dvs_reg[k]};
            bit_y   = trial_y >= {1'b0, dvs_reg[k]};
            if (bit_x) begin
                rem_x_next = 32'(trial_x - {1'b0, dvs_reg[k]});
            end else begin
                rem_x_next = trial_x[31:0];
            end
            if (bit_y) begin
                rem_y_next = 32'(trial_y - {1'b0, dvs_reg[k]});
            end else begin
                rem_y_next = trial_y[31:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= valid_reg[k];
            end
            if (en) begin
                rem_x_reg[k+1] <= rem_x_next;
                rem_y_reg[k+1] <= rem_y_next;
                dq_x_reg[k+1]  <= {dq_x_reg[k][62:0], bit_x};
                dq_y_reg[k+1]  <= {dq_y_reg[k][62:0], bit_y};
                dvs_reg[k+1]   <= dvs_reg[k];
                side_reg[k+1]  <= side_reg[k];
            end
        end
    end

    assign out_valid  = valid_reg[Steps];
    assign out_quot_x = dq_x_reg[Steps];
    assign out_quot_y = dq_y_reg[Steps];
    assign out_side   = side_reg[Steps];

endmodule

FILE: rtl/core/friction_kinematics_step.sv
// channel  | ports                     | word
// ---------+---------------------------+------------------------------------
// input    | s_valid s_ready s_data    | in_word_t: position, velocity, time
// result   | m_valid m_ready m_data    | out_word_t: position, velocity, flags
// config   | cfg_we cfg_wdata          | friction coefficient, Q8.8
//
// One word per cycle in and out while the pipeline advances; the path runs through the 33-stage
// square root and the 65-stage restoring divider (an input register, then one
// quotient bit a stage).
// The whole pipeline advances together; it holds only while a result waits
// at the output and m_ready is low. Synchronous active-low reset clears the
// valid bits and sets the coefficient to 1.0.
module friction_kinematics_step import fks_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam logic signed [65:0] PosMax = 66'sd2147483647;
    localparam logic signed [65:0] PosMin = -66'sd2147483648;

    logic        en;
    logic [15:0] fc_reg;
    logic [27:0] decel_reg;

    body_t       a_body_reg;
    logic        a_valid_reg;
    body_t       b_body_reg;
    logic        b_valid_reg;
    logic [63:0] b_sqx_reg;
    logic [63:0] b_sqy_reg;
    logic [58:0] b_at_reg;

    sqrt_side_t  sq_in_side;
    sqrt_side_t  sq_out_side;
    logic        sq_out_valid;
    logic [31:0] sq_root;

    mode_t       c_mode_next;
    logic [31:0] c_fac_next;
    logic        c_valid_reg;
    body_t       c_body_reg;
    mode_t       c_mode_reg;
    logic [31:0] c_root_reg;
    logic [31:0] c_fac_reg;

    logic        d_valid_reg;
    body_t       d_body_reg;
    mode_t       d_mode_reg;
    logic [31:0] d_root_reg;
    logic [63:0] d_prodx_reg;
    logic [63:0] d_prody_reg;

    logic [63:0] dv_add;
    logic [31:0] dv_divisor;
    div_side_t   dv_in_side;
    div_side_t   dv_out_side;
    logic        dv_out_valid;
    logic [63:0] dv_qx;
    logic [63:0] dv_qy;

    logic        f_valid_reg;
    div_side_t   f_side_reg;
    logic [63:0] f_qx_reg;
    logic [63:0] f_qy_reg;
    logic [32:0] f_mx_reg;
    logic [32:0] f_my_reg;
    logic [32:0] f_mx_next;
    logic [32:0] f_my_next;

    logic        g_valid_reg;
    div_side_t   g_side_reg;
    logic [63:0] g_qx_reg;
    logic [63:0] g_qy_reg;
    logic [63:0] g_px_reg;
    logic [63:0] g_py_reg;

    logic [64:0] h_rx;
    logic [64:0] h_ry;
    logic [63:0] h_dx_next;
    logic [63:0] h_dy_next;
    logic [31:0] h_vx_next;
    logic [31:0] h_vy_next;
    logic        h_valid_reg;
    body_t       h_body_reg;
    logic [63:0] h_dx_reg;
    logic [63:0] h_dy_reg;
    logic [31:0] h_vx_reg;
    logic [31:0] h_vy_reg;
    logic        h_stop_reg;

    logic signed [65:0] o_sx;
    logic signed [65:0] o_sy;
    out_word_t   o_data_next;
    out_word_t   o_data_reg;
    logic        o_valid_reg;

    assign en      = m_ready || !o_valid_reg;
    assign s_ready = en;

    // coefficient and the deceleration it implies
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg <= FRICTION_RESET;
        end else if (cfg_we) begin
            fc_reg <= cfg_wdata;
        end
        decel_reg <= 28'(((36'(DECEL_PER_COEF) * 36'(fc_reg)) + 36'd128) >> 8);
    end

    // stage a: magnitudes, clamp time at zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
        end
        if (en) begin
            a_body_reg.p_x   <= s_data.pos_x;
            a_body_reg.p_y   <= s_data.pos_y;
            a_body_reg.neg_x <= s_data.vel_x[31];
            a_body_reg.neg_y <= s_data.vel_y[31];
            a_body_reg.vm_x  <= s_data.vel_x[31] ? 32'(0 - s_data.vel_x) : s_data.vel_x;
            a_body_reg.vm_y  <= s_data.vel_y[31] ? 32'(0 - s_data.vel_y) : s_data.vel_y;
            a_body_reg.t     <= s_data.elapsed_time[31] ? '0 : s_data.elapsed_time[30:0];
        end
    end

    // stage b: squares and decel * time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
        if (en) begin
            b_body_reg <= a_body_reg;
            b_sqx_reg  <= a_body_reg.vm_x * a_body_reg.vm_x;
            b_sqy_reg  <= a_body_reg.vm_y * a_body_reg.vm_y;
            b_at_reg   <= decel_reg * a_body_reg.t;
        end
    end

    assign sq_in_side.body = b_body_reg;
    assign sq_in_side.at   = b_at_reg;

    fks_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b_valid_reg),
        .in_x      (b_sqx_reg + b_sqy_reg),
        .in_side   (sq_in_side),
        .out_valid (sq_out_valid),
        .out_root  (sq_root),
        .out_side  (sq_out_side)
    );

    // stage c: pick the case; stopping includes the exact-equality edge
    always_comb begin
        if (sq_root == '0) begin
            c_mode_next = MODE_REST;
        end else if (decel_reg == '0) begin
            c_mode_next = MODE_FREE;
        end else if ({11'b0, sq_root, 16'b0} <= sq_out_side.at) begin
            c_mode_next = MODE_STOP;
        end else begin
            c_mode_next = MODE_MOVE;
        end
        if (c_mode_next == MODE_STOP) begin
            c_fac_next = sq_root;
        end else begin
            c_fac_next = sq_root - sq_out_side.at[47:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= sq_out_valid;
            d_valid_reg <= c_valid_reg;
        end
        if (en) begin
            c_body_reg  <= sq_out_side.body;
            c_mode_reg  <= c_mode_next;
            c_root_reg  <= sq_root;
            c_fac_reg   <= c_fac_next;
            d_body_reg  <= c_body_reg;
            d_mode_reg  <= c_mode_reg;
            d_root_reg  <= c_root_reg;
            d_prodx_reg <= c_body_reg.vm_x * c_fac_reg;
            d_prody_reg <= c_body_reg.vm_y * c_fac_reg;
        end
    end

    // rounding term and divisor: 2A when stopping, S when still moving
    always_comb begin
        case (d_mode_reg)
            MODE_STOP: begin
                dv_add     = {36'b0, decel_reg};
                dv_divisor = {3'b0, decel_reg, 1'b0};
            end
            MODE_MOVE: begin
                dv_add     = {33'b0, d_root_reg[31:1]};
                dv_divisor = d_root_reg;
            end
            default: begin
                dv_add     = '0;
                dv_divisor = 32'd1;
            end
        endcase
    end

    assign dv_in_side.body = d_body_reg;
    assign dv_in_side.mode = d_mode_reg;

    fks_div u_div (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (d_valid_reg),
        .in_dividend_x (d_prodx_reg + dv_add),
        .in_dividend_y (d_prody_reg + dv_add),
        .in_divisor    (dv_divisor),
        .in_side       (dv_in_side),
        .out_valid     (dv_out_valid),
        .out_quot_x    (dv_qx),
        .out_quot_y    (dv_qy),
        .out_side      (dv_out_side)
    );

    // stage f: speed sum for the average; free motion uses 2|v|
    always_comb begin
        if (dv_out_side.mode == MODE_FREE) begin
            f_mx_next = {dv_out_side.body.vm_x, 1'b0};
            f_my_next = {dv_out_side.body.vm_y, 1'b0};
        end else begin
            f_mx_next = {1'b0, dv_out_side.body.vm_x} + {1'b0, dv_qx[31:0]};
            f_my_next = {1'b0, dv_out_side.body.vm_y} + {1'b0, dv_qy[31:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= dv_out_valid;
            g_valid_reg <= f_valid_reg;
        end
        if (en) begin
            f_side_reg <= dv_out_side;
            f_qx_reg   <= dv_qx;
            f_qy_reg   <= dv_qy;
            f_mx_reg   <= f_mx_next;
            f_my_reg   <= f_my_next;
            g_side_reg <= f_side_reg;
            g_qx_reg   <= f_qx_reg;
            g_qy_reg   <= f_qy_reg;
            g_px_reg   <= f_mx_reg * f_side_reg.body.t;
            g_py_reg   <= f_my_reg * f_side_reg.body.t;
        end
    end

    // stage h: displacement magnitude and new velocity
    always_comb begin
        h_rx = {1'b0, g_px_reg} + 65'd65536;
        h_ry = {1'b0, g_py_reg} + 65'd65536;
        case (g_side_reg.mode)
            MODE_STOP: begin
                h_dx_next = g_qx_reg;
                h_dy_next = g_qy_reg;
                h_vx_next = '0;
                h_vy_next = '0;
            end
            MODE_MOVE: begin
                h_dx_next = {16'b0, h_rx[64:17]};
                h_dy_next = {16'b0, h_ry[64:17]};
                h_vx_next = g_qx_reg[31:0];
                h_vy_next = g_qy_reg[31:0];
            end
            MODE_FREE: begin
                h_dx_next = {16'b0, h_rx[64:17]};
                h_dy_next = {16'b0, h_ry[64:17]};
                h_vx_next = g_side_reg.body.vm_x;
                h_vy_next = g_side_reg.body.vm_y;
            end
            default: begin
                h_dx_next = '0;
                h_dy_next = '0;
                h_vx_next = '0;
                h_vy_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
        end else if (en) begin
            h_valid_reg <= g_valid_reg;
        end
        if (en) begin
            h_body_reg <= g_side_reg.body;
            h_dx_reg   <= h_dx_next;
            h_dy_reg   <= h_dy_next;
            h_vx_reg   <= h_vx_next;
            h_vy_reg   <= h_vy_next;
            h_stop_reg <= g_side_reg.mode == MODE_STOP;
        end
    end

    // output stage: apply sign, add to position, clamp
    always_comb begin
        if (h_body_reg.neg_x) begin
            o_sx = {{34{h_body_reg.p_x[31]}}, h_body_reg.p_x} - $signed({2'b00, h_dx_reg});
        end else begin
            o_sx = {{34{h_body_reg.p_x[31]}}, h_body_reg.p_x} + $signed({2'b00, h_dx_reg});
        end
        if (h_body_reg.neg_y) begin
            o_sy = {{34{h_body_reg.p_y[31]}}, h_body_reg.p_y} - $signed({2'b00, h_dy_reg});
        end else begin
            o_sy = {{34{h_body_reg.p_y[31]}}, h_body_reg.p_y} + $signed({2'b00, h_dy_reg});
        end

        o_data_next.saturated = 1'b0;
        if (o_sx > PosMax) begin
            o_data_next.new_pos_x = 32'sh7fffffff;
            o_data_next.saturated = 1'b1;
        end else if (o_sx < PosMin) begin
            o_data_next.new_pos_x = 32'sh80000000;
            o_data_next.saturated = 1'b1;
        end else begin
            o_data_next.new_pos_x = o_sx[31:0];
        end
        if (o_sy > PosMax) begin
            o_data_next.new_pos_y = 32'sh7fffffff;
            o_data_next.saturated = 1'b1;
        end else if (o_sy < PosMin) begin
            o_data_next.new_pos_y = 32'sh80000000;
            o_data_next.saturated = 1'b1;
        end else begin
            o_data_next.new_pos_y = o_sy[31:0];
        end
        o_data_next.new_vel_x = h_body_reg.neg_x ? 32'(0 - h_vx_reg) : h_vx_reg;
        o_data_next.new_vel_y = h_body_reg.neg_y ? 32'(0 - h_vy_reg) : h_vy_reg;
        o_data_next.stopped   = h_stop_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= h_valid_reg;
        end
        if (en) begin
            o_data_reg <= o_data_next;
        end
    end

    assign m_valid = o_valid_reg;
    assign m_data  = o_data_reg;

endmodule

FILE: verif/tb_top.sv
module tb_top;
    import fks_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 120;

    logic      aclk;
    logic      aresetn;
    logic      cfg_we;
    logic [15:0] cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    friction_kinematics_step uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    typedef struct {
        logic [15:0] coef;
        in_word_t    w;
        bit          typed;
        out_word_t   res;
    } kin_row_t;

    out_word_t   motion_q[$];
    logic [15:0] friction_q8;
    int          fail_count;
    int          cycle_count;
    int          burst_left;
    int          ready_mode;
    int          ready_span;
    // typed result travels with the word that is being offered
    bit          s_typed;
    out_word_t   s_typed_res;

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic out_word_t kin_predict(in_word_t w, logic [15:0] coef);
        longint unsigned t, a, s, ds, nm;
        longint unsigned vm[2];
        longint signed   p[2], v[2], nv[2], d[2], np;
        bit              stop, sat;
        out_word_t       r;
        p[0] = w.pos_x;
        p[1] = w.pos_y;
        v[0] = w.vel_x;
        v[1] = w.vel_y;
        nv[0] = 0; nv[1] = 0; d[0] = 0; d[1] = 0;
        stop = 0;
        sat = 0;
        t = (w.elapsed_time < 0) ? 64'd0 : longint'(w.elapsed_time);
        for (int k = 0; k < 2; k++) vm[k] = (v[k] < 0) ? -v[k] : v[k];
        s = int_sqrt(vm[0] * vm[0] + vm[1] * vm[1]);
        a = (longint'(DECEL_PER_COEF) * coef + 128) >> 8;
        if (s == 0) begin
            // at rest
        end else if (a == 0) begin
            for (int k = 0; k < 2; k++) begin
                nv[k] = v[k];
                nm = (vm[k] * t + 32768) >> 16;
                d[k] = (v[k] < 0) ? -longint'(nm) : longint'(nm);
            end
        end else if ((s << 16) <= a * t) begin
            stop = 1;
            for (int k = 0; k < 2; k++) begin
                nm = (vm[k] * s + a) / (2 * a);
                d[k] = (v[k] < 0) ? -longint'(nm) : longint'(nm);
            end
        end else begin
            ds = (a * t) >> 16;
            for (int k = 0; k < 2; k++) begin
                nm = (vm[k] * (s - ds) + s / 2) / s;
                nv[k] = (v[k] < 0) ? -longint'(nm) : longint'(nm);
                nm = ((vm[k] + nm) * t + 65536) >> 17;
                d[k] = (v[k] < 0) ? -longint'(nm) : longint'(nm);
            end
        end
        for (int k = 0; k < 2; k++) begin
            np = p[k] + d[k];
            if (np > 64'sd2147483647) begin
                np = 64'sd2147483647;
                sat = 1;
            end else if (np < -64'sd2147483648) begin
                np = -64'sd2147483648;
                sat = 1;
            end
            if (k == 0) begin
                r.new_pos_x = np[31:0];
                r.new_vel_x = nv[k][31:0];
            end else begin
                r.new_pos_y = np[31:0];
                r.new_vel_y = nv[k][31:0];
            end
        end
        r.stopped = stop;
        r.saturated = sat;
        return r;
    endfunction

    // directed rows; typed results where the answer is plain passthrough
    function automatic kin_row_t mk_row(logic [15:0] coef, logic [31:0] px, logic [31:0] py,
                                        logic [31:0] vx, logic [31:0] vy, logic [31:0] t,
                                        bit typed);
        kin_row_t row;
        row.coef = coef;
        row.w = '{px, py, vx, vy, t};
        row.typed = typed;
        row.res = '{px, py, typed && vx == 0 && vy == 0 ? 32'd0 : vx,
                    typed && vx == 0 && vy == 0 ? 32'd0 : vy, 1'b0, 1'b0};
        return row;
    endfunction

    kin_row_t directed[$];

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("friction_kinematics_step test failed");
            $finish;
        end
    end

    // receiver stall pattern: phases of always-ready, coin flip, mostly stalled
    always @(posedge aclk) begin
        if (ready_span == 0) begin
            ready_mode <= $urandom_range(0, 2);
            ready_span <= $urandom_range(10, 200);
        end else begin
            ready_span <= ready_span - 1;
        end
        case (ready_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= $urandom_range(0, 1);
            end
            default: begin
                m_ready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                motion_q.push_back(s_typed ? s_typed_res : kin_predict(s_data, friction_q8));
            end
            if (m_valid && m_ready) begin
                if (motion_q.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    want = motion_q.pop_front();
                    if (m_data.new_pos_x !== want.new_pos_x) begin
                        $error("new_pos_x exp %0d got %0d", want.new_pos_x, m_data.new_pos_x);
                        fail_count++;
                    end
                    if (m_data.new_pos_y !== want.new_pos_y) begin
                        $error("new_pos_y exp %0d got %0d", want.new_pos_y, m_data.new_pos_y);
                        fail_count++;
                    end
                    if (m_data.new_vel_x !== want.new_vel_x) begin
                        $error("new_vel_x exp %0d got %0d", want.new_vel_x, m_data.new_vel_x);
                        fail_count++;
                    end
                    if (m_data.new_vel_y !== want.new_vel_y) begin
                        $error("new_vel_y exp %0d got %0d", want.new_vel_y, m_data.new_vel_y);
                        fail_count++;
                    end
                    if (m_data.stopped !== want.stopped) begin
                        $error("stopped exp %0b got %0b", want.stopped, m_data.stopped);
                        fail_count++;
                    end
                    if (m_data.saturated !== want.saturated) begin
                        $error("saturated exp %0b got %0b", want.saturated, m_data.saturated);
                        fail_count++;
                    end
                end
            end
        end
    end

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(in_word_t w);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(posedge aclk);
            else @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_and_set(logic [15:0] coef);
        s_valid <= 1'b0;
        burst_left = 0;
        // first wait for the edge at which the last accepted word is queued
        @(posedge aclk);
        while (motion_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= coef;
        @(posedge aclk);
        cfg_we <= 1'b0;
        friction_q8 = coef;
    endtask

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom;
            2: return $urandom_range(0, 32'h000f_ffff);
            3: return -$urandom_range(0, 32'h000f_ffff);
            default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_time();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return -$urandom_range(0, 32'h0010_0000);
            2: return $urandom_range(0, 32'h0100_0000);
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return 32'h7fff_ffff - $urandom_range(0, 32'h00ff_ffff);
            1: return 32'h8000_0000 + $urandom_range(0, 32'h00ff_ffff);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [15:0] sweep[7];
        in_word_t w;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        friction_q8 = FRICTION_RESET;
        fail_count = 0;
        cycle_count = 0;
        burst_left = 0;
        ready_mode = 0;
        ready_span = 0;
        s_typed = 1'b0;
        s_typed_res = '0;

        directed.push_back(mk_row(16'd256, 32'h0005_0000, 32'hfffb_0000, 0, 0, 32'h0001_0000, 1));
        directed.push_back(mk_row(16'd256, 32'h0001_0000, 32'h0002_0000,
                                  32'h0003_0000, 32'hfffc_0000, 32'hffff_0000, 1));
        directed.push_back(mk_row(16'd256, 32'h7fff_ffff, 32'h8000_0000,
                                  32'h0003_0000, 32'h0004_0000, 32'h0000_0000, 1));
        directed.push_back(mk_row(16'd256, 32'h1234_5678, 32'h8765_4321,
                                  32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1));
        directed.push_back(mk_row(16'd256, 0, 0, 32'h0003_0000, 32'h0004_0000, 32'h000a_0000, 0));
        // stop time equals the interval exactly
        directed.push_back(mk_row(16'd256, 0, 0, 32'd642253, 0, 32'h0001_0000, 0));
        directed.push_back(mk_row(16'd256, 0, 0, 32'hfff0_0000, 32'h0020_0000, 32'h0000_4000, 0));
        directed.push_back(mk_row(16'd256, 32'h7fff_ffff, 32'h8000_0000,
                                  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0));
        directed.push_back(mk_row(16'd256, 32'h8000_0000, 32'h7fff_0000,
                                  32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 0));
        directed.push_back(mk_row(16'd256, 32'h7fff_0000, 0, 32'h7fff_ffff, 0, 32'h0000_0100, 0));
        directed.push_back(mk_row(16'd256, 0, 0, 32'd1, 32'hffff_ffff, 32'h0000_0001, 0));
        directed.push_back(mk_row(16'd0, 0, 0, 32'h0002_0000, 32'hfffe_0000, 32'h0003_0000, 0));
        directed.push_back(mk_row(16'd0, 32'h7fff_ffff, 32'h8000_0000,
                                  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0));
        directed.push_back(mk_row(16'd0, 32'h0005_0000, 0, 0, 0, 32'h7fff_ffff, 1));
        directed.push_back(mk_row(16'd0, 0, 0, 32'h0001_0000, 0, 32'hffff_0000, 1));
        directed.push_back(mk_row(16'd65535, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0));
        directed.push_back(mk_row(16'd65535, 0, 0, 32'h0100_0000, 32'h8000_0000, 32'h0000_0010, 0));
        directed.push_back(mk_row(16'd1, 0, 0, 32'h0100_0000, 32'hff00_0000, 32'h0010_0000, 0));
        directed.push_back(mk_row(16'd1, 32'h7fff_ffff, 0, 32'h7fff_ffff, 0, 32'h7fff_ffff, 0));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            if (directed[i].coef != friction_q8) drain_and_set(directed[i].coef);
            s_typed <= directed[i].typed;
            s_typed_res <= directed[i].res;
            send_word(directed[i].w);
        end
        s_typed <= 1'b0;

        sweep = '{16'd256, 16'd0, 16'd65535, 16'd1, 16'd128, 16'd4096, 16'($urandom)};
        foreach (sweep[ph]) begin
            drain_and_set(sweep[ph]);
            for (int n = 0; n < 185; n++) begin
                w.pos_x = rand_pos();
                w.pos_y = rand_pos();
                w.vel_x = rand_vel();
                w.vel_y = rand_vel();
                w.elapsed_time = rand_time();
                send_word(w);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (motion_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("friction_kinematics_step test passed");
        end else begin
            $display("friction_kinematics_step test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/fks_pkg.sv
rtl/core/fks_sqrt.sv
rtl/core/fks_div.sv
rtl/core/friction_kinematics_step.sv
verif/tb_top.sv
